### rtl/indexed_list_store_macros.svh
// Assertion macros shared by the list store RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Expression holds at every clock edge.
`define ILS_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ILS_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ILS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ils_pkg.sv
// Shared constants, command codes and control structs for the list store.
// Used by ils_ctrl, ils_cell and indexed_list_store.
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_READ = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_AT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL  = 3'd4;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  at;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

  // status of the request being accepted
  typedef struct packed {
    logic             is_read;
    logic             read_ok;
    logic             done;
    logic [LEN_W-1:0] length;
  } res_t;

endpackage

### rtl/ils_ctrl.sv
// Element count and command decode for the list store.
// Depends on ils_pkg and indexed_list_store_macros.svh.
`include "indexed_list_store_macros.svh"

module ils_ctrl
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] value,
  output cell_ctl_t         ctl,
  output res_t              res
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] pos_x;
  logic [IDX_W-1:0] cnt_x;
  logic             room;
  logic             ins_ok;
  logic             del_ok;
  logic             read_ok;

  assign pos_x = IDX_W'(position);
  assign cnt_x = IDX_W'(count);
  assign room  = count < CNT_W'(CAPACITY);

  always_comb begin
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    read_ok = 1'b0;
    ctl.at  = pos_x;
    case (cmd)
      CMD_READ: read_ok = pos_x < cnt_x;
      CMD_HEAD: begin
        ins_ok = room;
        ctl.at = '0;
      end
      CMD_TAIL: begin
        ins_ok = room;
        ctl.at = cnt_x;
      end
      CMD_AT:   ins_ok = room && (pos_x <= cnt_x);
      CMD_DEL:  del_ok = pos_x < cnt_x;
      default:  ;
    endcase
    ctl.ins   = accept && ins_ok;
    ctl.del   = accept && del_ok;
    ctl.value = value;
  end

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign res.is_read = cmd == CMD_READ;
  assign res.read_ok = read_ok;
  assign res.done    = ins_ok || del_ok || read_ok;
  assign res.length  = LEN_W'(IDX_W'(count_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  `ILS_ALWAYS(a_count_bound, count <= CNT_W'(CAPACITY), "count above capacity")
  `ILS_NEXT(a_ins_grows, ctl.ins, count == $past(count) + CNT_W'(1), "insert lost")
  `ILS_NEXT(a_del_shrinks, ctl.del, count == $past(count) - CNT_W'(1), "delete lost")
  `ILS_IMPLY(a_read_no_move, accept && res.is_read, !ctl.ins && !ctl.del,
    "read changed the store")

endmodule

### rtl/ils_cell.sv
// One element of the list store chain; takes from its neighbors on a shift.
// Depends on ils_pkg.
module ils_cell
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd
);

  // insert: cells past the gap take from the left, the gap takes the value
  // delete: cells from the gap on take from the right
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (idx > ctl.at) begin
        data <= left;
      end else if (idx == ctl.at) begin
        data <= ctl.value;
      end
    end else if (ctl.del && idx >= ctl.at) begin
      data <= right;
    end
  end

  assign rd = (idx == ctl.at) ? data : '0;

endmodule

### rtl/indexed_list_store.sv
// Top level of the list store: count/decode control, a chain of element
// cells and the result register. Depends on ils_pkg, ils_ctrl and ils_cell.
//
// Usage:
// - Requests come in on in_valid/in_ready with cmd, position and value.
//   Commands: read, insert at head, insert at tail, insert before position,
//   delete at position. Inserts and deletes shift all later cells by one
//   place at once, so no command walks the list.
// - Each request gives exactly one result on out_valid/out_ready with
//   read_value, hit, done_res and the length after the command.
// - The result is registered: a request accepted at one edge has its result
//   valid after that edge. One request is taken per cycle while the receiver
//   keeps up, as the whole cell chain updates at once.
// - A read out of range gives read_value -1 and hit clear; a refused insert
//   or delete gives done_res clear and leaves the store as it was.
// - When the receiver stalls, the result holds in the output register and
//   in_ready drops until it is taken; a request is accepted in the same
//   cycle the waiting result leaves.
// - Reset empties the list (length 0) and clears out_valid. Cell contents
//   are not cleared; only positions below the length are ever read.
module indexed_list_store
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] read_value,
  output logic              hit,
  output logic              done_res,
  output logic [LEN_W-1:0]  length
);

  logic              accept;
  cell_ctl_t         ctl;
  res_t              res;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] rd_or;
  logic [DATA_W-1:0] read_value_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd),
    .position (position),
    .value    (value),
    .ctl      (ctl),
    .res      (res)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    ils_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .data  (cell_data[i]),
      .rd    (cell_rd[i])
    );
  end

  // only the addressed cell drives a nonzero word
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    read_value_next = '0;
    if (res.is_read) begin
      read_value_next = res.read_ok ? rd_or : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= read_value_next;
      hit        <= res.read_ok;
      done_res   <= res.done;
      length     <= res.length;
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for indexed_list_store: directed edge cases, then random
// grow/shrink traffic under varying backpressure, checked against a queue-based list model.
// Depends on ils_pkg and the indexed_list_store RTL.
module tb_top;
  import ils_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int BURST_LEN     = 130;
  localparam int PHASE_ITEMS   = 440;

  // codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              hit;
    logic              done;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd        = CMD_READ;
  logic [POS_W-1:0]  position   = '0;
  logic [DATA_W-1:0] value      = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [DATA_W-1:0] read_value;
  logic              hit;
  logic              done_res;
  logic [LEN_W-1:0]  length;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  logic [DATA_W-1:0] elements[$];
  list_result_t      pending_results[$];

  int err_count     = 0;
  int req_count     = 0;
  int res_count     = 0;
  int full_refusals = 0;
  int peak_len      = 0;
  int idle_cycles   = 0;

  indexed_list_store i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .hit        (hit),
    .done_res   (done_res),
    .length     (length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the list model and return the result it should give.
  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] c,
                                                  input logic [POS_W-1:0] p,
                                                  input logic [DATA_W-1:0] v);
    list_result_t r;
    int n;
    r = '0;
    n = elements.size();
    case (c)
      CMD_READ: begin
        if (p < n) begin
          r.read_value = elements[p];
          r.hit = 1'b1;
          r.done = 1'b1;
        end else begin
          r.read_value = '1;
        end
      end
      CMD_HEAD: begin
        if (n < CAPACITY) begin
          elements.push_front(v);
          r.done = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      CMD_TAIL: begin
        if (n < CAPACITY) begin
          elements.push_back(v);
          r.done = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      CMD_AT: begin
        if (n >= CAPACITY) begin
          full_refusals++;
        end else if (p <= n) begin
          elements.insert(int'(p), v);
          r.done = 1'b1;
        end
      end
      CMD_DEL: begin
        if (p < n) begin
          elements.delete(int'(p));
          r.done = 1'b1;
        end
      end
      default: ;
    endcase
    if (elements.size() > peak_len) peak_len = elements.size();
    r.length = LEN_W'(elements.size());
    return r;
  endfunction

  // Present one request, hold it until accepted, then record its expected result.
  task automatic send_req(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                          input logic [DATA_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    position <= p;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_list_cmd(c, p, v));
    req_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Empty store: every read, delete, positional insert and spare code must be refused.
  task automatic test_empty_store();
    send_req(CMD_READ, 7'd0, 32'h0);
    send_req(CMD_READ, 7'd127, 32'hFFFF_FFFF);
    send_req(CMD_DEL, 7'd0, 32'h0);
    send_req(CMD_DEL, 7'd127, 32'h0);
    send_req(CMD_AT, 7'd1, 32'h1234_5678);
    send_req(CMD_SPARE5, 7'd0, 32'h5555_5555);
    send_req(CMD_SPARE6, 7'd64, 32'hAAAA_AAAA);
    send_req(CMD_SPARE7, 7'd127, 32'hFFFF_FFFF);
  endtask

  // Every command on a short list, with value extremes and range boundaries.
  task automatic test_edit_ops();
    send_req(CMD_HEAD, 7'd0, 32'h7FFF_FFFF);
    send_req(CMD_TAIL, 7'd0, 32'h8000_0000);
    send_req(CMD_AT, 7'd1, 32'hFFFF_FFFF);
    send_req(CMD_AT, 7'd3, 32'h0000_0000);   // position == length appends
    send_req(CMD_AT, 7'd5, 32'h0000_0001);   // past the end
    send_req(CMD_READ, 7'd0, 32'h0);
    send_req(CMD_READ, 7'd1, 32'h0);
    send_req(CMD_READ, 7'd2, 32'h0);
    send_req(CMD_READ, 7'd3, 32'h0);
    send_req(CMD_READ, 7'd4, 32'h0);
    send_req(CMD_DEL, 7'd3, 32'h0);
    send_req(CMD_DEL, 7'd0, 32'h0);
    send_req(CMD_DEL, 7'd2, 32'h0);
    send_req(CMD_READ, 7'd0, 32'h0);
    send_req(CMD_READ, 7'd1, 32'h0);
    send_req(CMD_DEL, 7'd0, 32'h0);
    send_req(CMD_DEL, 7'd0, 32'h0);
  endtask

  // Alternating bursts that fill the store past capacity and drain it empty,
  // with a small share of fully random requests mixed in.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int grow_pct;
    int n;
    int r;
    logic [CMD_W-1:0]  c;
    logic [POS_W-1:0]  p;
    logic [DATA_W-1:0] v;
    for (sent = 0; sent < n_items; sent++) begin
      grow_pct = ((sent / BURST_LEN) % 2 == 0) ? 80 : 10;
      n = elements.size();
      case ($urandom_range(7))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = 32'hFFFF_FFFF;
        3:       v = 32'h0000_0000;
        default: v = $urandom;
      endcase
      r = $urandom_range(99);
      if (r < 8) begin
        c = CMD_W'($urandom_range(7));
        p = POS_W'($urandom_range(127));
      end else if ($urandom_range(99) < grow_pct) begin
        case ($urandom_range(2))
          0:       c = CMD_HEAD;
          1:       c = CMD_TAIL;
          default: c = CMD_AT;
        endcase
        p = POS_W'($urandom_range(n));
      end else begin
        c = ($urandom_range(99) < 30) ? CMD_READ : CMD_DEL;
        p = POS_W'($urandom_range(n));
      end
      send_req(c, p, v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker and stall watchdog
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      res_count++;
      if (pending_results.size() == 0) begin
        err_count++;
        $error("result with no request pending");
      end else begin
        exp_r = pending_results.pop_front();
        if (read_value !== exp_r.read_value) begin
          err_count++;
          $error("read_value: expected %0d, actual %0d",
                 $signed(exp_r.read_value), $signed(read_value));
        end
        if (hit !== exp_r.hit) begin
          err_count++;
          $error("hit: expected %0b, actual %0b", exp_r.hit, hit);
        end
        if (done_res !== exp_r.done) begin
          err_count++;
          $error("done_res: expected %0b, actual %0b", exp_r.done, done_res);
        end
        if (length !== exp_r.length) begin
          err_count++;
          $error("length: expected %0d, actual %0d", exp_r.length, length);
        end
      end
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 63;
    test_empty_store();
    test_edit_ops();
    wait_idle();
    test_random_traffic(PHASE_ITEMS);
    wait_idle();

    send_idle_pct = 63;
    recv_idle_pct = 32;
    test_random_traffic(PHASE_ITEMS);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(PHASE_ITEMS);
    wait_idle();

    $display("covered %0d requests and %0d checked results over three backpressure mixes",
             req_count, res_count);
    $display("list peaked at %0d entries; %0d inserts refused on a full store",
             peak_len, full_refusals);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
